FILE: hw/rtl/dcbv_pkg.sv
// Shared types and constants of the dual channel boxcar voltage core.
// No dependencies; every other file of the block depends on this package.
package dcbv_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int CHANNEL_W = 8;
  localparam int VOLT_W    = 18;

  localparam int DEFAULT_WINDOW_DEPTH = 64;

  localparam int SAMPLE_MAX = 4095;
  localparam int MID_CODE   = 2048;  // converter code of zero volts
  localparam int VOLT_MAX   = 131071;
  localparam int VOLT_MIN   = -131072;

  // operation codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // channel numbers
  localparam logic [CHANNEL_W-1:0] CH_A = 8'd0;
  localparam logic [CHANNEL_W-1:0] CH_B = 8'd1;

  // per-cycle control from the top level to each window store
  typedef struct packed {
    logic store;   // write the sample pair this cycle
    logic primed;  // every window entry has been written once
  } win_ctrl_t;

  // one result item
  typedef struct packed {
    logic signed [VOLT_W-1:0] voltage;
    logic                     invalid;
  } res_t;

endpackage

FILE: hw/rtl/dcbv_req_if.sv
// Request channel: store a sample pair or read a channel voltage.
// Depends on dcbv_pkg for field widths.
interface dcbv_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [dcbv_pkg::SAMPLE_W-1:0]  sample_a;
  logic [dcbv_pkg::SAMPLE_W-1:0]  sample_b;
  logic [dcbv_pkg::CHANNEL_W-1:0] channel;

  modport source(output valid, operation, sample_a, sample_b, channel, input ready);
  modport sink(input valid, operation, sample_a, sample_b, channel, output ready);
endinterface

FILE: hw/rtl/dcbv_rsp_if.sv
// Response channel: one voltage item per read request.
// Depends on dcbv_pkg for field widths.
interface dcbv_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [dcbv_pkg::VOLT_W-1:0] voltage;
  logic                               invalid;

  modport source(output valid, voltage, invalid, input ready);
  modport sink(input valid, voltage, invalid, output ready);
endinterface

FILE: hw/rtl/dcbv_window.sv
// One channel's sample window memory and its running sum.
// Depends on dcbv_pkg.
module dcbv_window #(
  parameter int WINDOW_DEPTH = dcbv_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int IDX_W        = $clog2(WINDOW_DEPTH),
  parameter int SUM_W        = $clog2(WINDOW_DEPTH * dcbv_pkg::SAMPLE_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcbv_pkg::win_ctrl_t           ctrl,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [IDX_W-1:0]              rd_idx,
  input  logic [dcbv_pkg::SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]              sum
);
  import dcbv_pkg::*;

  localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(WINDOW_DEPTH * SAMPLE_MAX);

  logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;   // always holds mem[wr_idx]
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    sum_next;

  // rd_idx follows the next write index, so the entry about to be
  // overwritten is already in rd_data; a write and that read never collide
  always_ff @(posedge clk) begin
    if (ctrl.store) begin
      mem[wr_idx] <= sample;
    end
    rd_data <= mem[rd_idx];
  end

  // entries not yet written since reset count as zero
  assign old_sample = ctrl.primed ? rd_data : '0;
  assign sum_next   = sum - SUM_W'(old_sample) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.store) begin
      sum <= sum_next;
    end
  end

  a_sum_range: assert property (@(posedge clk) disable iff (rst) sum <= SUM_LIMIT)
    else $error("window sum above full scale");

endmodule

FILE: hw/rtl/dcbv_result.sv
// Voltage conversion, saturation and the output register with skid stage.
// Depends on dcbv_pkg and dcbv_rsp_if.
module dcbv_result #(
  parameter int WINDOW_DEPTH = dcbv_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int SUM_W        = $clog2(WINDOW_DEPTH * dcbv_pkg::SAMPLE_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_req,
  input  logic [dcbv_pkg::CHANNEL_W-1:0] channel,
  input  logic [SUM_W-1:0]               sum_a,
  input  logic [SUM_W-1:0]               sum_b,
  output logic                           up_ready,
  dcbv_rsp_if.source                     rsp
);
  import dcbv_pkg::*;

  localparam int EXT_W = (SUM_W + 1 > VOLT_W) ? SUM_W + 1 : VOLT_W;
  localparam logic [EXT_W-1:0] OFFSET  = EXT_W'(WINDOW_DEPTH * MID_CODE);
  localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(VOLT_MAX);
  localparam logic [EXT_W-1:0] MIN_EXT = EXT_W'(VOLT_MIN);

  logic [SUM_W-1:0]        sel_sum;
  logic signed [EXT_W-1:0] diff;
  res_t                    res_new;
  res_t                    out_q;
  res_t                    skid_q;
  logic                    out_valid;
  logic                    skid_valid;

  always_comb begin
    res_new = '0;
    sel_sum = sum_a;
    diff    = '0;
    priority if (channel == CH_A) begin
      sel_sum = sum_a;
    end else if (channel == CH_B) begin
      sel_sum = sum_b;
    end else begin
      res_new.invalid = 1'b1;
    end
    diff = $signed({{(EXT_W - SUM_W){1'b0}}, sel_sum} - OFFSET);
    if (!res_new.invalid) begin
      priority if (diff > $signed(MAX_EXT)) begin
        res_new.voltage = VOLT_W'(VOLT_MAX);
      end else if (diff < $signed(MIN_EXT)) begin
        res_new.voltage = VOLT_W'(VOLT_MIN);
      end else begin
        res_new.voltage = diff[VOLT_W-1:0];
      end
    end
  end

  assign up_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= rd_req;
      end
    end else if (rd_req) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      out_q <= skid_valid ? skid_q : res_new;
    end else if (rd_req) begin
      skid_q <= res_new;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.voltage = out_q.voltage;
  assign rsp.invalid = out_q.invalid;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output stage is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    !skid_valid && rd_req && out_valid && !rsp.ready |=> skid_valid)
    else $error("stalled read item was dropped");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !rd_req)
    else $error("read accepted with both output stages full");

endmodule

FILE: hw/rtl/dual_channel_boxcar_voltage_core.sv
// Top level of the dual channel boxcar voltage core.
// Depends on dcbv_pkg, dcbv_req_if, dcbv_rsp_if, dcbv_window, dcbv_result.
//
//   port  direction  items                          handshake
//   req   in         store pair / read channel      valid & ready
//   rsp   out        voltage + invalid, per read    valid & ready
//
// One item per cycle while req.ready is high: a store updates both running sums
// at the edge it is accepted, so a read in the very next cycle already sees it.
// A read result reaches rsp through the output register, via the skid register if rsp stalls.
// Stores need no result slot, but like reads they wait while req.ready is
// low; req.ready drops only while both the output register and the skid
// register hold results.
// Reset (rst, synchronous) clears sums, the write index and the primed flag;
// window memories are not swept, unwritten entries read as zero until the
// index has wrapped once.
module dual_channel_boxcar_voltage_core #(
  parameter int WINDOW_DEPTH = dcbv_pkg::DEFAULT_WINDOW_DEPTH
) (
  input logic        clk,
  input logic        rst,
  dcbv_req_if.sink   req,
  dcbv_rsp_if.source rsp
);
  import dcbv_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

  logic             req_acc;
  logic             rd_req;
  logic             up_ready;
  win_ctrl_t        win_ctrl;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] rd_idx;
  logic             primed;
  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;

  assign req.ready = up_ready;
  assign req_acc   = req.valid && up_ready;
  assign rd_req    = req_acc && (req.operation == OP_READ);

  assign win_ctrl.store  = req_acc && (req.operation == OP_STORE);
  assign win_ctrl.primed = primed;

  // shared wrapping write index
  always_comb begin
    write_index_next = write_index;
    if (win_ctrl.store) begin
      write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
    end
  end

  // prefetch address: the entry the next store will overwrite
  assign rd_idx = rst ? '0 : write_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      primed      <= 1'b0;
    end else begin
      write_index <= write_index_next;
      if (win_ctrl.store && write_index == LAST_IDX) begin
        primed <= 1'b1;
      end
    end
  end

  dcbv_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .IDX_W(IDX_W),
    .SUM_W(SUM_W)
  ) u_win_a (
    .clk(clk),
    .rst(rst),
    .ctrl(win_ctrl),
    .wr_idx(write_index),
    .rd_idx(rd_idx),
    .sample(req.sample_a),
    .sum(sum_a)
  );

  dcbv_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .IDX_W(IDX_W),
    .SUM_W(SUM_W)
  ) u_win_b (
    .clk(clk),
    .rst(rst),
    .ctrl(win_ctrl),
    .wr_idx(write_index),
    .rd_idx(rd_idx),
    .sample(req.sample_b),
    .sum(sum_b)
  );

  dcbv_result #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SUM_W(SUM_W)
  ) u_result (
    .clk(clk),
    .rst(rst),
    .rd_req(rd_req),
    .channel(req.channel),
    .sum_a(sum_a),
    .sum_b(sum_b),
    .up_ready(up_ready),
    .rsp(rsp)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    write_index <= LAST_IDX)
    else $error("write index past window end");

  a_primed_on_wrap: assert property (@(posedge clk) disable iff (rst)
    win_ctrl.store && write_index == LAST_IDX |=> primed && write_index == '0)
    else $error("window wrap not tracked");

endmodule

FILE: verif/tb_dual_channel_boxcar_voltage_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for dual_channel_boxcar_voltage_core.
// Needs dcbv_pkg, dcbv_req_if, dcbv_rsp_if and the core RTL; nothing else.
module tb_dual_channel_boxcar_voltage_core;
  import dcbv_pkg::*;

  localparam int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH;
  localparam int ITEM_TARGET  = 650;
  localparam int IDLE_PCT     = 29;

  localparam logic [SAMPLE_W-1:0] S_MAX = SAMPLE_W'(SAMPLE_MAX);
  localparam logic [SAMPLE_W-1:0] S_MID = SAMPLE_W'(MID_CODE);

  // Tracks both boxcar windows and queues the voltage expected for each read.
  class boxcar_scoreboard #(int DEPTH = 64);
    logic [SAMPLE_W-1:0] win_a [DEPTH];
    logic [SAMPLE_W-1:0] win_b [DEPTH];
    int unsigned         slot;
    int unsigned         total_a;
    int unsigned         total_b;
    res_t                expected_volts [$];
    int                  failures;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        win_a[i] = '0;
        win_b[i] = '0;
      end
      slot     = 0;
      total_a  = 0;
      total_b  = 0;
      failures = 0;
    endfunction

    // window total -> offset-binary removed, clamped to the result width
    function logic signed [VOLT_W-1:0] scaled(int unsigned total);
      int v;
      v = int'(total) - DEPTH * MID_CODE;
      if (v > VOLT_MAX) v = VOLT_MAX;
      if (v < VOLT_MIN) v = VOLT_MIN;
      return v[VOLT_W-1:0];
    endfunction

    function void note_request(logic op, logic [SAMPLE_W-1:0] sa, logic [SAMPLE_W-1:0] sb,
                               logic [CHANNEL_W-1:0] ch);
      res_t r;
      if (op == OP_STORE) begin
        total_a     = total_a - win_a[slot] + sa;
        total_b     = total_b - win_b[slot] + sb;
        win_a[slot] = sa;
        win_b[slot] = sb;
        slot        = (slot == DEPTH - 1) ? 0 : slot + 1;
      end else begin
        r.invalid = 1'b0;
        if (ch == CH_A) begin
          r.voltage = scaled(total_a);
        end else if (ch == CH_B) begin
          r.voltage = scaled(total_b);
        end else begin
          r.voltage = '0;
          r.invalid = 1'b1;
        end
        expected_volts.push_back(r);
      end
    endfunction

    function void flag(string what, int want, int got);
      failures++;
      if (failures <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    function void check_result(logic signed [VOLT_W-1:0] v, logic inv);
      res_t want;
      if (expected_volts.size() == 0) begin
        flag("unexpected result voltage", 0, v);
      end else begin
        want = expected_volts.pop_front();
        if (want.voltage !== v) flag("voltage", want.voltage, v);
        if (want.invalid !== inv) flag("invalid", want.invalid, inv);
      end
    endfunction

    function int pending();
      return expected_volts.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;       // when set, neither side idles
  int   items_sent;

  dcbv_req_if req ();
  dcbv_rsp_if rsp ();

  boxcar_scoreboard #(.DEPTH(WINDOW_DEPTH)) board;

  dual_channel_boxcar_voltage_core #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until
  // the core takes it. Valid stays high into the next item unless it idles.
  task automatic send(logic op, logic [SAMPLE_W-1:0] sa, logic [SAMPLE_W-1:0] sb,
                      logic [CHANNEL_W-1:0] ch);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.sample_a  <= sa;
    req.sample_b  <= sb;
    req.channel   <= ch;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_request(op, sa, sb, ch);
    items_sent++;
  endtask

  // Sender holds off until every read result has been returned.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // One full window of constant samples, or up to five more, then read both channels;
  // takes the sums to their extremes and wraps the write index.
  task automatic fill_window(logic [SAMPLE_W-1:0] sa, logic [SAMPLE_W-1:0] sb);
    repeat (WINDOW_DEPTH + $urandom_range(5)) send(OP_STORE, sa, sb, CH_A);
    send(OP_READ, '0, '0, CH_A);
    send(OP_READ, '0, '0, CH_B);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return S_MAX;
    return SAMPLE_W'($urandom_range(SAMPLE_MAX));
  endfunction

  function automatic logic [CHANNEL_W-1:0] pick_channel();
    int r;
    r = $urandom_range(99);
    if (r < 45) return CH_A;
    if (r < 90) return CH_B;
    return CHANNEL_W'($urandom_range(255));
  endfunction

  // Response side: check every accepted result, then stall at random.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) board.check_result(rsp.voltage, rsp.invalid);
      rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL dual_channel_boxcar_voltage_core");
    $finish;
  end

  initial begin
    board      = new();
    steady     = 1'b0;
    items_sent = 0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.operation <= OP_STORE;
    req.sample_a  <= '0;
    req.sample_b  <= '0;
    req.channel   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reads of the cleared windows (most negative voltage), channel
    // numbers that do not exist, extreme samples, a read right after a store.
    send(OP_READ, '0, '0, CH_A);
    send(OP_READ, '0, '0, CH_B);
    send(OP_READ, '0, '0, 8'd2);
    send(OP_READ, '0, '0, 8'hFF);
    send(OP_READ, '0, '0, 8'h80);
    send(OP_STORE, S_MAX, '0, CH_A);
    send(OP_READ, '0, '0, CH_A);
    send(OP_READ, '0, '0, CH_B);
    send(OP_STORE, '0, S_MAX, CH_B);
    send(OP_READ, '0, '0, CH_A);
    send(OP_READ, '0, '0, CH_B);
    send(OP_STORE, S_MID, S_MID, 8'hFF);
    send(OP_STORE, S_MAX, S_MAX, CH_A);
    send(OP_READ, '0, '0, CH_A);
    send(OP_READ, '0, '0, CH_B);
    send(OP_READ, S_MAX, S_MAX, 8'h7F);
    send(OP_STORE, '0, '0, CH_A);
    send(OP_STORE, 12'h001, 12'hFFE, CH_B);
    send(OP_READ, '0, '0, CH_A);
    send(OP_READ, '0, '0, CH_B);
    send(OP_READ, '0, '0, 8'h55);
    send(OP_READ, '0, '0, 8'hAA);
    drain();

    // Full-scale windows: channel A at top with B at bottom, then swapped.
    // The first one runs with no idling on either side.
    steady = 1'b1;
    fill_window(S_MAX, '0);
    steady = 1'b0;
    fill_window('0, S_MAX);

    // Random mix, mostly stores with a read about every third item.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent == 350) steady = 1'b1;
      if (items_sent == 430) begin
        steady = 1'b0;
        drain();
      end
      if ($urandom_range(99) < 35)
        send(OP_READ, pick_sample(), pick_sample(), pick_channel());
      else
        send(OP_STORE, pick_sample(), pick_sample(), pick_channel());
    end

    req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0)
      $display("PASS dual_channel_boxcar_voltage_core");
    else
      $display("FAIL dual_channel_boxcar_voltage_core");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dcbv_pkg.sv
hw/rtl/dcbv_req_if.sv
hw/rtl/dcbv_rsp_if.sv
hw/rtl/dcbv_window.sv
hw/rtl/dcbv_result.sv
hw/rtl/dual_channel_boxcar_voltage_core.sv
verif/tb_dual_channel_boxcar_voltage_core.sv
